/* hw/rtl/cost_pkg.sv */
// Shared types and constants for the consume-once slot table.
// Holds the beat structs for both channels, request codes and status codes.
// No dependencies.
`timescale 1ns / 1ps

package cost_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int HANDLE_BITS = 32;
    localparam int IDX_W       = $clog2(MAX_SLOTS);
    localparam int COUNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int REQ_W       = 3;
    localparam int SLOT_W      = 7;
    localparam int CAP_W       = 7;
    localparam int STATUS_W    = 4;
    localparam int REM_W       = 7;
    localparam int HANDLE_W    = 32;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic [REQ_W-1:0] REQ_APPEND      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SEQ_CONSUME = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LOCK        = 3'd2;
    localparam logic [REQ_W-1:0] REQ_IDX_CONSUME = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CONSUME_ALL = 3'd4;
    localparam logic [REQ_W-1:0] REQ_UNLOCK      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK              = 4'd0;
    localparam logic [STATUS_W-1:0] ST_FULL            = 4'd1;
    localparam logic [STATUS_W-1:0] ST_SEQ_LOCKED      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_LOCKED  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_CONSUMED_BEFORE = 4'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_LOCKED      = 4'd5;
    localparam logic [STATUS_W-1:0] ST_RANGE           = 4'd6;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE       = 4'd7;
    localparam logic [STATUS_W-1:0] ST_LEFT            = 4'd8;

    localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'd0;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [HANDLE_W-1:0] handle_in;
        logic [SLOT_W-1:0]   slot_number;
    } t_req;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [REM_W-1:0]    remaining_count;
    } t_rsp;

endpackage

/* hw/rtl/consume_once_slot_table_unit.sv */
// An accepted request moves through the pending stage into the output register.
// Throughput: one request per cycle; the request stall follows the result stall
// through one pending stage and the output register.
// Reset clears the entry and unconsumed counts, the lock flag and all consumed
// flags, and sets capacity to 64. The handle memory is not cleared.
// Top level of the consume-once slot table; depends on cost_pkg.
`timescale 1ns / 1ps

module consume_once_slot_table_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cost_pkg::t_req                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cost_pkg::t_rsp                      o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cost_pkg::APB_AW-1:0]         paddr,
    input  logic [cost_pkg::APB_DW-1:0]         pwdata,
    output logic [cost_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import cost_pkg::*;

    logic [CAP_W-1:0]     r_capacity;
    logic [MAX_SLOTS-1:0] r_used, n_used;
    logic [COUNT_W-1:0]   r_entry_cnt, n_entry_cnt;
    logic [COUNT_W-1:0]   r_unc_cnt, n_unc_cnt;
    logic                 r_lock, n_lock;

    logic [HANDLE_W-1:0]  r_handle_mem [MAX_SLOTS];
    logic [HANDLE_W-1:0]  r_rd_data;

    logic                 r_pend;
    logic                 r_pend_found;
    logic [STATUS_W-1:0]  r_pend_status;
    logic [REM_W-1:0]     r_pend_remain;

    logic                 r_out_valid;
    t_rsp                 r_out_data;

    logic                 in_accept;
    logic                 pend_move;
    logic                 mem_we;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_addr;
    logic                 n_found;
    logic [STATUS_W-1:0]  n_status;
    logic [COUNT_W-1:0]   eff_cap;
    logic [IDX_W-1:0]     first_free;
    logic [IDX_W-1:0]     slot_idx;
    logic                 cfg_we;

    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite && (paddr[APB_AW-1] == ADDR_CAPACITY[APB_AW-1]);
    assign prdata    = (paddr[APB_AW-1] == ADDR_CAPACITY[APB_AW-1])
                       ? APB_DW'(r_capacity) : '0;

    assign pend_move  = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !pend_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = COUNT_W'(1);
        end else if (COUNT_W'(r_capacity) > COUNT_W'(MAX_SLOTS)) begin
            eff_cap = COUNT_W'(MAX_SLOTS);
        end else begin
            eff_cap = COUNT_W'(r_capacity);
        end
    end

    always_comb begin
        first_free = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                first_free = IDX_W'(i);
            end
        end
    end

    assign slot_idx = IDX_W'(i_in_data.slot_number - SLOT_W'(1));

    always_comb begin
        n_used      = r_used;
        n_entry_cnt = r_entry_cnt;
        n_unc_cnt   = r_unc_cnt;
        n_lock      = r_lock;
        n_found     = 1'b0;
        n_status    = ST_OK;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = r_entry_cnt[IDX_W-1:0];
        case (i_in_data.req_type)
            REQ_APPEND: begin
                if (r_entry_cnt >= eff_cap || r_entry_cnt >= COUNT_W'(MAX_SLOTS)) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we                            = 1'b1;
                    n_used[r_entry_cnt[IDX_W-1:0]]    = 1'b0;
                    n_entry_cnt                       = r_entry_cnt + COUNT_W'(1);
                    n_unc_cnt                         = r_unc_cnt + COUNT_W'(1);
                end
            end
            REQ_SEQ_CONSUME: begin
                if (r_lock) begin
                    n_status = ST_SEQ_LOCKED;
                end else if (r_unc_cnt != '0) begin
                    mem_re             = 1'b1;
                    mem_addr           = first_free;
                    n_used[first_free] = 1'b1;
                    n_unc_cnt          = r_unc_cnt - COUNT_W'(1);
                    n_found            = 1'b1;
                end
            end
            REQ_LOCK: begin
                if (r_lock) begin
                    n_status = ST_ALREADY_LOCKED;
                end else if (r_unc_cnt != r_entry_cnt) begin
                    n_status = ST_CONSUMED_BEFORE;
                end else begin
                    n_lock = 1'b1;
                end
            end
            REQ_IDX_CONSUME: begin
                if (!r_lock) begin
                    n_status = ST_NOT_LOCKED;
                end else if (i_in_data.slot_number == '0
                             || COUNT_W'(i_in_data.slot_number) > r_entry_cnt) begin
                    n_status = ST_RANGE;
                end else if (r_used[slot_idx]) begin
                    n_status = ST_DUPLICATE;
                end else begin
                    mem_re           = 1'b1;
                    mem_addr         = slot_idx;
                    n_used[slot_idx] = 1'b1;
                    n_unc_cnt        = r_unc_cnt - COUNT_W'(1);
                    n_found          = 1'b1;
                end
            end
            REQ_CONSUME_ALL: begin
                if (!r_lock) begin
                    n_status = ST_NOT_LOCKED;
                end else begin
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        if (COUNT_W'(i) < r_entry_cnt) begin
                            n_used[i] = 1'b1;
                        end
                    end
                    n_unc_cnt = '0;
                end
            end
            REQ_UNLOCK: begin
                if (!r_lock) begin
                    n_status = ST_NOT_LOCKED;
                end else if (r_unc_cnt != '0) begin
                    n_status = ST_LEFT;
                end else begin
                    n_lock = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_used      <= '0;
            r_entry_cnt <= '0;
            r_unc_cnt   <= '0;
            r_lock      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                r_capacity <= pwdata[CAP_W-1:0];
            end
            if (in_accept) begin
                r_used      <= n_used;
                r_entry_cnt <= n_entry_cnt;
                r_unc_cnt   <= n_unc_cnt;
                r_lock      <= n_lock;
                r_pend      <= 1'b1;
            end else if (pend_move) begin
                r_pend <= 1'b0;
            end
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pend_found  <= n_found;
            r_pend_status <= n_status;
            r_pend_remain <= REM_W'(n_unc_cnt);
        end
        if (pend_move) begin
            r_out_data.handle_out      <= r_pend_found ? r_rd_data : '0;
            r_out_data.found           <= r_pend_found;
            r_out_data.status          <= r_pend_status;
            r_out_data.remaining_count <= r_pend_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && mem_we) begin
            r_handle_mem[mem_addr] <= i_in_data.handle_in;
        end
        if (in_accept && mem_re) begin
            r_rd_data <= r_handle_mem[mem_addr];
        end
    end

endmodule

/* tb/sv/slot_table_checker.sv */
// Scoreboard for the consume-once slot table: watches the request, result and register
// channels, keeps its own copy of the table state and compares every result beat.
// Depends on cost_pkg.
`timescale 1ns / 1ps

module slot_table_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  cost_pkg::t_req                i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  cost_pkg::t_rsp                i_out_data,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [cost_pkg::APB_AW-1:0]   i_paddr,
    input  logic [cost_pkg::APB_DW-1:0]   i_pwdata,
    input  logic [cost_pkg::APB_DW-1:0]   i_prdata,
    input  logic                          i_pready,
    output int                            o_fail_count,
    output int                            o_pending
);
    import cost_pkg::*;

    logic [HANDLE_W-1:0] slot_handle [MAX_SLOTS];
    logic                slot_taken  [MAX_SLOTS];
    int                  fill_count;
    int                  live_count;
    logic                locked;
    logic [CAP_W-1:0]    cap_reg;
    t_rsp                rsp_due_q [$];
    int                  fail_total;

    function automatic t_rsp apply_request(input t_req r);
        t_rsp rsp;
        int   eff_cap;
        int   take;
        rsp  = '0;
        take = -1;
        if (cap_reg == 0) begin
            eff_cap = 1;
        end else if (cap_reg > MAX_SLOTS) begin
            eff_cap = MAX_SLOTS;
        end else begin
            eff_cap = int'(cap_reg);
        end
        case (r.req_type)
            REQ_APPEND: begin
                if (fill_count >= eff_cap) begin
                    rsp.status = ST_FULL;
                end else begin
                    slot_handle[fill_count] = r.handle_in;
                    slot_taken[fill_count]  = 1'b0;
                    fill_count++;
                    live_count++;
                end
            end
            REQ_SEQ_CONSUME: begin
                if (locked) begin
                    rsp.status = ST_SEQ_LOCKED;
                end else begin
                    for (int pos = 0; pos < fill_count; pos++) begin
                        if (take < 0 && !slot_taken[pos]) begin
                            take = pos;
                        end
                    end
                end
            end
            REQ_LOCK: begin
                if (locked) begin
                    rsp.status = ST_ALREADY_LOCKED;
                end else if (live_count != fill_count) begin
                    rsp.status = ST_CONSUMED_BEFORE;
                end else begin
                    locked = 1'b1;
                end
            end
            REQ_IDX_CONSUME: begin
                if (!locked) begin
                    rsp.status = ST_NOT_LOCKED;
                end else if (r.slot_number == 0 || int'(r.slot_number) > fill_count) begin
                    rsp.status = ST_RANGE;
                end else if (slot_taken[int'(r.slot_number) - 1]) begin
                    rsp.status = ST_DUPLICATE;
                end else begin
                    take = int'(r.slot_number) - 1;
                end
            end
            REQ_CONSUME_ALL: begin
                if (!locked) begin
                    rsp.status = ST_NOT_LOCKED;
                end else begin
                    for (int pos = 0; pos < fill_count; pos++) begin
                        slot_taken[pos] = 1'b1;
                    end
                    live_count = 0;
                end
            end
            REQ_UNLOCK: begin
                if (!locked) begin
                    rsp.status = ST_NOT_LOCKED;
                end else if (live_count != 0) begin
                    rsp.status = ST_LEFT;
                end else begin
                    locked = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (take >= 0) begin
            slot_taken[take] = 1'b1;
            live_count--;
            rsp.handle_out = slot_handle[take];
            rsp.found      = 1'b1;
        end
        rsp.remaining_count = REM_W'(live_count);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            fill_count = 0;
            live_count = 0;
            locked     = 1'b0;
            cap_reg    = CAP_RESET;
            foreach (slot_taken[k]) slot_taken[k] = 1'b0;
            rsp_due_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (rsp_due_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("[%0t] result beat with nothing expected: %h %0d %0d %0d",
                                 $realtime, i_out_data.handle_out, i_out_data.found,
                                 i_out_data.status, i_out_data.remaining_count);
                    end
                end else begin
                    want = rsp_due_q.pop_front();
                    if (i_out_data !== want) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("[%0t] result mismatch: expected %h %0d %0d %0d",
                                     $realtime, want.handle_out, want.found,
                                     want.status, want.remaining_count);
                            $display("    got handle %h found %0d status %0d remaining %0d",
                                     i_out_data.handle_out, i_out_data.found,
                                     i_out_data.status, i_out_data.remaining_count);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                rsp_due_q.push_back(apply_request(i_in_data));
            end
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_CAPACITY) begin
                if (i_pwrite) begin
                    cap_reg = i_pwdata[CAP_W-1:0];
                end else if (i_prdata !== APB_DW'(cap_reg)) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("[%0t] capacity read mismatch: expected %0d, got %0d",
                                 $realtime, cap_reg, i_prdata);
                    end
                end
            end
        end
        o_pending    <= rsp_due_q.size();
        o_fail_count <= fail_total;
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for consume_once_slot_table_unit: drives directed and random requests,
// capacity register writes and random idling, and reports the verdict.
// Depends on cost_pkg, consume_once_slot_table_unit and slot_table_checker.
`timescale 1ns / 1ps

module tb;
    import cost_pkg::*;

    localparam int                 CYCLE_LIMIT   = 400000;
    localparam logic [REQ_W-1:0]   REQ_UNUSED_LO = 3'd6;
    localparam logic [REQ_W-1:0]   REQ_UNUSED_HI = 3'd7;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    t_req                in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_rsp                out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    int                  fail_count;
    int                  pending_count;
    int                  cycle_count = 0;
    bit                  send_idle;
    bit                  recv_idle;

    consume_once_slot_table_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    slot_table_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (recv_idle && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_req(input t_req r);
        if (send_idle && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_op(input logic [REQ_W-1:0] op, input logic [HANDLE_W-1:0] h,
                           input logic [SLOT_W-1:0] s);
        t_req r;
        r.req_type    = op;
        r.handle_in   = h;
        r.slot_number = s;
        push_req(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [APB_AW-1:0] a,
                              input logic [APB_DW-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        logic [APB_DW-1:0] word;
        drain();
        word = {$urandom} & ~APB_DW'({CAP_W{1'b1}});
        apb_access(1'b1, ADDR_CAPACITY, word | APB_DW'(v));
        apb_access(1'b0, ADDR_CAPACITY, '0);
    endtask

    function automatic t_req random_req(input bit lock_session);
        t_req r;
        int   pick;
        pick          = $urandom_range(0, 99);
        r.handle_in   = $urandom;
        r.slot_number = SLOT_W'($urandom_range(0, 127));
        r.req_type    = $urandom_range(0, 1) ? REQ_UNUSED_LO : REQ_UNUSED_HI;
        if (lock_session) begin
            if (pick < 12) begin
                r.req_type = REQ_APPEND;
            end else if (pick < 72) begin
                r.req_type = REQ_IDX_CONSUME;
                if (pick < 62) r.slot_number = SLOT_W'($urandom_range(1, 48));
            end else if (pick < 80) begin
                r.req_type = REQ_SEQ_CONSUME;
            end else if (pick < 87) begin
                r.req_type = REQ_LOCK;
            end else if (pick < 95) begin
                r.req_type = REQ_UNLOCK;
            end
        end else begin
            if (pick < 20) begin
                r.req_type = REQ_APPEND;
            end else if (pick < 65) begin
                r.req_type = REQ_SEQ_CONSUME;
            end else if (pick < 72) begin
                r.req_type = REQ_LOCK;
            end else if (pick < 80) begin
                r.req_type = REQ_IDX_CONSUME;
            end else if (pick < 86) begin
                r.req_type = REQ_CONSUME_ALL;
            end else if (pick < 93) begin
                r.req_type = REQ_UNLOCK;
            end
        end
        return r;
    endfunction

    task automatic run_random(input int count, input bit lock_session);
        repeat (count) push_req(random_req(lock_session));
    endtask

    initial begin
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A capacity of zero behaves as one slot.
        set_capacity(7'd0);
        send_op(REQ_SEQ_CONSUME, 32'h0, 7'd0);
        send_op(REQ_UNLOCK, 32'h0, 7'd0);
        send_op(REQ_IDX_CONSUME, 32'h0, 7'd1);
        send_op(REQ_CONSUME_ALL, 32'h0, 7'd0);
        send_op(REQ_UNUSED_LO, 32'hFFFF_FFFF, 7'd127);
        send_op(REQ_UNUSED_HI, 32'h1234_5678, 7'd64);
        send_op(REQ_APPEND, 32'h0000_0000, 7'd0);
        send_op(REQ_APPEND, 32'hFFFF_FFFF, 7'd0);

        // Capacity above the slot count behaves as the slot count.
        set_capacity(7'd127);
        send_op(REQ_LOCK, 32'h0, 7'd0);
        send_op(REQ_LOCK, 32'h0, 7'd0);
        send_op(REQ_SEQ_CONSUME, 32'h0, 7'd0);
        send_op(REQ_APPEND, 32'hFFFF_FFFF, 7'd0);
        send_op(REQ_APPEND, 32'h5A5A_5A5A, 7'd0);
        send_op(REQ_IDX_CONSUME, 32'h0, 7'd0);
        send_op(REQ_IDX_CONSUME, 32'h0, 7'd127);
        send_op(REQ_IDX_CONSUME, 32'h0, 7'd4);
        send_op(REQ_IDX_CONSUME, 32'h0, 7'd2);
        send_op(REQ_IDX_CONSUME, 32'h0, 7'd2);
        send_op(REQ_UNLOCK, 32'h0, 7'd0);
        send_op(REQ_UNUSED_HI, 32'h0, 7'd0);

        run_random(175, 1'b1);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        run_random(175, 1'b1);
        send_op(REQ_CONSUME_ALL, $urandom, 7'd0);
        send_op(REQ_UNLOCK, $urandom, 7'd0);
        send_op(REQ_LOCK, $urandom, 7'd0);
        send_op(REQ_UNLOCK, $urandom, 7'd0);

        // Capacity below the current entry count keeps the entries and refuses appends.
        set_capacity(7'd1);
        send_idle = 1'b1;
        run_random(260, 1'b0);
        set_capacity(7'd50);
        send_idle = 1'b0;
        recv_idle = 1'b1;
        run_random(260, 1'b0);
        set_capacity(7'd64);
        send_idle = 1'b1;
        run_random(260, 1'b0);
        set_capacity(7'd127);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        run_random(260, 1'b0);
        drain();

        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
